// ----- sv/cra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cra_pkg - shared constants for the camera ray attitude rotator
// Field widths, register indexes, clamp limits, sine coefficients and the
// half view angle phase table.
// ----------------------------------------------------------------------------
package cra_pkg;

   localparam int VEC_W      = 24;
   localparam int OFFSET_W   = 12;
   localparam int TIME_W     = 32;
   localparam int PHASE_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CAM_WIDTH_W = 12;
   localparam int VIEW_W     = 8;
   localparam int TIMEOUT_W  = 16;

   localparam int WIDTH_MIN = 60;
   localparam int WIDTH_MAX = 1080;
   localparam int VIEW_MIN  = 20;
   localparam int VIEW_MAX  = 80;
   localparam int VIEW_ENTRIES = VIEW_MAX - VIEW_MIN + 1;

   localparam logic [31:0] SIN_A = 32'd1686629713;
   localparam logic [31:0] SIN_B = 32'd688904867;
   localparam logic [31:0] SIN_C = 32'd76016978;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam int PhaseDiv  = 720;
   localparam int PhaseHalf = 360;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM1_WIDTH   = 3'd0,
      CSR_CAM1_VIEW    = 3'd1,
      CSR_CAM2_WIDTH   = 3'd2,
      CSR_CAM2_VIEW    = 3'd3,
      CSR_CAM1_TIMEOUT = 3'd4,
      CSR_CAM2_TIMEOUT = 3'd5
   } csr_index_type;

   typedef logic [PHASE_W-1:0] phase_table_type [0:VIEW_ENTRIES-1];

   // round(view * 2^32 / 720) for each integer view angle
   function automatic phase_table_type build_view_phase();
      phase_table_type tab;
      logic [63:0]     num;
      for (int i = 0; i < VIEW_ENTRIES; i++) begin
         num    = (64'(i + VIEW_MIN) << 32) + 64'(PhaseHalf);
         tab[i] = 32'(num / PhaseDiv);
      end
      return tab;
   endfunction

   localparam phase_table_type VIEW_PHASE = build_view_phase();

endpackage
`default_nettype wire

// ----- sv/camera_ray_attitude_rotate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// camera_ray_attitude_rotate - pinhole camera ray rotated by vehicle attitude
// Builds the ray [focal, x, -y] from a pixel offset, rotates it by roll and
// pitch (and by yaw for the follow camera) and keeps per camera validity.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | carries
//  req_    | in        | valid / stall      | measurement or status item
//  rsp_    | out       | valid / stall      | one result per item
//  csr_    | in        | valid / ready      | register index and write data
//
//  A status item or an unhealthy measurement goes from transfer straight to
//  the wait state. A healthy measurement walks a 68 step micro program on
//  one shared 34x34 multiplier plus a one bit per cycle divider for the
//  focal length, with a second pass of the rotation steps for the follow
//  camera. req_stall is high until the result is in the output register; a
//  waiting result does not stop the next item. Reset clears the control
//  state, validity flags, last seen times and timeouts, and loads default geometry.
// ----------------------------------------------------------------------------
module camera_ray_attitude_rotate #(
   parameter int ANGLE_WIDTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_action,
   input  wire logic                                   req_camera_sel,
   input  wire logic signed [cra_pkg::OFFSET_W-1:0]    req_offset_x,
   input  wire logic signed [cra_pkg::OFFSET_W-1:0]    req_offset_y,
   input  wire logic                                   req_healthy,
   input  wire logic signed [ANGLE_WIDTH-1:0]          req_roll_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0]          req_pitch_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0]          req_yaw_angle,
   input  wire logic [cra_pkg::TIME_W-1:0]             req_time_ms,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_updated,
   output logic                                        rsp_camera_out,
   output logic signed [cra_pkg::VEC_W-1:0]            rsp_corr_x,
   output logic signed [cra_pkg::VEC_W-1:0]            rsp_corr_y,
   output logic signed [cra_pkg::VEC_W-1:0]            rsp_ray_x,
   output logic signed [cra_pkg::VEC_W-1:0]            rsp_ray_y,
   output logic signed [cra_pkg::VEC_W-1:0]            rsp_ray_z,
   output logic                                        rsp_follow_valid,
   output logic                                        rsp_avoid_valid,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cra_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [cra_pkg::CSR_DATA_W-1:0]         csr_data
);

   // operand, product and divider widths
   localparam int OP_W   = 34;
   localparam int PROD_W = 2 * OP_W;
   localparam int NUM_W  = 43 + FRAC_BITS;
   localparam int DEN_W  = 32;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int STEP_W = 7;
   localparam int VIDX_W = $clog2(cra_pkg::VIEW_ENTRIES);

   localparam logic [STEP_W-1:0] STEP_ROT = 7'd11;
   localparam logic [STEP_W-1:0] STEP_YAW = 7'd31;

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< 29;
   localparam logic signed [PROD_W-1:0] VEC_MAX  = PROD_W'(8388607);
   localparam logic signed [PROD_W-1:0] VEC_MIN  = -PROD_W'(8388608);

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV, ST_WAIT} state_type;

   typedef enum logic [3:0] {
      M_SINLOAD, M_RND, M_SUBR, M_ADDR, M_SINFIN,
      M_ACC0, M_ACC, M_OUT, M_FNUM, M_END
   } mode_type;

   typedef enum logic [4:0] {
      OP_ZERO, OP_Z, OP_Z2, OP_T, OP_SH, OP_CH, OP_SR, OP_CR, OP_SP, OP_CP,
      OP_SY, OP_CY, OP_AP, OP_BP, OP_TMP, OP_M, OP_V0, OP_V1, OP_V2, OP_NSP,
      OP_SIN_A, OP_SIN_B, OP_SIN_C, OP_WIDTH
   } opsel_type;

   typedef enum logic [3:0] {
      D_NONE, D_Z2, D_T, D_SH, D_CH, D_SR, D_CR, D_SP, D_CP, D_SY, D_CY,
      D_AP, D_BP, D_TMP, D_M
   } dst_type;

   typedef enum logic [1:0] {PH_VIEW, PH_ROLL, PH_PITCH, PH_YAW} phsel_type;
   typedef enum logic [1:0] {OUT_X, OUT_Y, OUT_Z} outsel_type;

   typedef struct packed {
      mode_type   mode;
      opsel_type  a;
      opsel_type  b;
      opsel_type  c;
      dst_type    dst;
      phsel_type  ph;
      logic       cos;
      outsel_type out;
   } uop_type;

   // control state
   state_type              state_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   pass_ff;
   logic [DCNT_W-1:0]      dcnt_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             cam_valid_ff;
   logic [cra_pkg::TIME_W-1:0] last_seen_ff [2];

   // configuration
   logic [cra_pkg::CAM_WIDTH_W-1:0] cfg_width_ff   [2];
   logic [cra_pkg::VIEW_W-1:0]      cfg_view_ff    [2];
   logic [cra_pkg::TIMEOUT_W-1:0]   cfg_timeout_ff [2];

   // item and working registers
   logic                          cam_ff;
   logic [ANGLE_WIDTH-1:0]        roll_ff, pitch_ff, yaw_ff;
   logic signed [OP_W-1:0]        z_ff, z2_ff, t_ff, sh_ff, ch_ff;
   logic signed [OP_W-1:0]        sr_ff, cr_ff, sp_ff, cp_ff, sy_ff, cy_ff;
   logic signed [OP_W-1:0]        ap_ff, bp_ff, tmp_ff, m_ff;
   logic signed [OP_W-1:0]        v0_ff, v1_ff, v2_ff;
   logic                          neg_ff;
   logic signed [PROD_W-1:0]      acc_ff;
   logic [NUM_W-1:0]              num_ff;
   logic [DEN_W-1:0]              den_ff, rem_ff;

   // result being built and the output register
   logic                          res_updated_ff, res_camera_ff;
   logic signed [cra_pkg::VEC_W-1:0] res_corr_x_ff, res_corr_y_ff;
   logic signed [cra_pkg::VEC_W-1:0] res_ray_x_ff, res_ray_y_ff, res_ray_z_ff;
   logic                          rsp_updated_ff, rsp_camera_ff;
   logic signed [cra_pkg::VEC_W-1:0] rsp_corr_x_ff, rsp_corr_y_ff;
   logic signed [cra_pkg::VEC_W-1:0] rsp_ray_x_ff, rsp_ray_y_ff, rsp_ray_z_ff;
   logic                          rsp_follow_ff, rsp_avoid_ff;

   // combinational datapath
   uop_type                       uop;
   logic signed [OP_W-1:0]        opa, opb, opc, wval;
   logic signed [PROD_W-1:0]      prod, rnd_src, rnd_val;
   logic signed [OP_W-1:0]        rnd_t;
   logic [cra_pkg::CAM_WIDTH_W-1:0] width_c;
   logic [cra_pkg::VIEW_W-1:0]    view_c;
   logic [VIDX_W-1:0]             view_idx;
   logic [cra_pkg::PHASE_W-1:0]   ph_base, ph_sel;
   logic [30:0]                   z_fold;
   logic [DEN_W:0]                rem_sh;
   logic                          qbit;
   logic [NUM_W-1:0]              num_in;
   logic [cra_pkg::TIME_W-1:0]    elapsed0, elapsed1;

   function automatic logic signed [PROD_W-1:0] rnd30(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] mag;
      mag = v[PROD_W-1] ? -v : v;
      mag = (mag + RND_HALF) >>> 30;
      return v[PROD_W-1] ? -mag : mag;
   endfunction

   function automatic logic signed [cra_pkg::VEC_W-1:0] sat_vec(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] c;
      c = v;
      if (v > VEC_MAX) c = VEC_MAX;
      if (v < VEC_MIN) c = VEC_MIN;
      return c[cra_pkg::VEC_W-1:0];
   endfunction

   function automatic uop_type mk(input mode_type md, input opsel_type a,
                                  input opsel_type b, input opsel_type c,
                                  input dst_type d, input outsel_type o);
      uop_type u;
      u      = '0;
      u.mode = md;
      u.a    = a;
      u.b    = b;
      u.c    = c;
      u.dst  = d;
      u.out  = o;
      return u;
   endfunction

   // one quarter wave polynomial evaluation, five steps
   function automatic uop_type sine_uop(input logic [2:0] off, input dst_type d,
                                        input phsel_type ph, input logic cs);
      uop_type u;
      u = '0;
      case (off)
         3'd0: begin
            u.mode = M_SINLOAD;
            u.ph   = ph;
            u.cos  = cs;
         end
         3'd1: u = mk(M_RND, OP_Z, OP_Z, OP_ZERO, D_Z2, OUT_X);
         3'd2: u = mk(M_SUBR, OP_Z2, OP_SIN_C, OP_SIN_B, D_T, OUT_X);
         3'd3: u = mk(M_SUBR, OP_Z2, OP_T, OP_SIN_A, D_T, OUT_X);
         default: u = mk(M_SINFIN, OP_Z, OP_T, OP_ZERO, d, OUT_X);
      endcase
      return u;
   endfunction

   function automatic logic signed [OP_W-1:0] operand(input opsel_type s);
      logic signed [OP_W-1:0] r;
      case (s)
         OP_Z:     r = z_ff;
         OP_Z2:    r = z2_ff;
         OP_T:     r = t_ff;
         OP_SH:    r = sh_ff;
         OP_CH:    r = ch_ff;
         OP_SR:    r = sr_ff;
         OP_CR:    r = cr_ff;
         OP_SP:    r = sp_ff;
         OP_CP:    r = cp_ff;
         OP_SY:    r = sy_ff;
         OP_CY:    r = cy_ff;
         OP_AP:    r = ap_ff;
         OP_BP:    r = bp_ff;
         OP_TMP:   r = tmp_ff;
         OP_M:     r = m_ff;
         OP_V0:    r = v0_ff;
         OP_V1:    r = v1_ff;
         OP_V2:    r = v2_ff;
         OP_NSP:   r = -sp_ff;
         OP_SIN_A: r = OP_W'(cra_pkg::SIN_A);
         OP_SIN_B: r = OP_W'(cra_pkg::SIN_B);
         OP_SIN_C: r = OP_W'(cra_pkg::SIN_C);
         OP_WIDTH: r = OP_W'(width_c);
         default:  r = '0;
      endcase
      return r;
   endfunction

   // micro program
   always_comb begin
      case (step_ff)
         7'd0:  uop = sine_uop(3'd0, D_SH, PH_VIEW, 1'b0);
         7'd1:  uop = sine_uop(3'd1, D_SH, PH_VIEW, 1'b0);
         7'd2:  uop = sine_uop(3'd2, D_SH, PH_VIEW, 1'b0);
         7'd3:  uop = sine_uop(3'd3, D_SH, PH_VIEW, 1'b0);
         7'd4:  uop = sine_uop(3'd4, D_SH, PH_VIEW, 1'b0);
         7'd5:  uop = sine_uop(3'd0, D_CH, PH_VIEW, 1'b1);
         7'd6:  uop = sine_uop(3'd1, D_CH, PH_VIEW, 1'b1);
         7'd7:  uop = sine_uop(3'd2, D_CH, PH_VIEW, 1'b1);
         7'd8:  uop = sine_uop(3'd3, D_CH, PH_VIEW, 1'b1);
         7'd9:  uop = sine_uop(3'd4, D_CH, PH_VIEW, 1'b1);
         7'd10: uop = mk(M_FNUM, OP_WIDTH, OP_CH, OP_ZERO, D_NONE, OUT_X);
         7'd11: uop = sine_uop(3'd0, D_SR, PH_ROLL, 1'b0);
         7'd12: uop = sine_uop(3'd1, D_SR, PH_ROLL, 1'b0);
         7'd13: uop = sine_uop(3'd2, D_SR, PH_ROLL, 1'b0);
         7'd14: uop = sine_uop(3'd3, D_SR, PH_ROLL, 1'b0);
         7'd15: uop = sine_uop(3'd4, D_SR, PH_ROLL, 1'b0);
         7'd16: uop = sine_uop(3'd0, D_CR, PH_ROLL, 1'b1);
         7'd17: uop = sine_uop(3'd1, D_CR, PH_ROLL, 1'b1);
         7'd18: uop = sine_uop(3'd2, D_CR, PH_ROLL, 1'b1);
         7'd19: uop = sine_uop(3'd3, D_CR, PH_ROLL, 1'b1);
         7'd20: uop = sine_uop(3'd4, D_CR, PH_ROLL, 1'b1);
         7'd21: uop = sine_uop(3'd0, D_SP, PH_PITCH, 1'b0);
         7'd22: uop = sine_uop(3'd1, D_SP, PH_PITCH, 1'b0);
         7'd23: uop = sine_uop(3'd2, D_SP, PH_PITCH, 1'b0);
         7'd24: uop = sine_uop(3'd3, D_SP, PH_PITCH, 1'b0);
         7'd25: uop = sine_uop(3'd4, D_SP, PH_PITCH, 1'b0);
         7'd26: uop = sine_uop(3'd0, D_CP, PH_PITCH, 1'b1);
         7'd27: uop = sine_uop(3'd1, D_CP, PH_PITCH, 1'b1);
         7'd28: uop = sine_uop(3'd2, D_CP, PH_PITCH, 1'b1);
         7'd29: uop = sine_uop(3'd3, D_CP, PH_PITCH, 1'b1);
         7'd30: uop = sine_uop(3'd4, D_CP, PH_PITCH, 1'b1);
         7'd31: uop = sine_uop(3'd0, D_SY, PH_YAW, 1'b0);
         7'd32: uop = sine_uop(3'd1, D_SY, PH_YAW, 1'b0);
         7'd33: uop = sine_uop(3'd2, D_SY, PH_YAW, 1'b0);
         7'd34: uop = sine_uop(3'd3, D_SY, PH_YAW, 1'b0);
         7'd35: uop = sine_uop(3'd4, D_SY, PH_YAW, 1'b0);
         7'd36: uop = sine_uop(3'd0, D_CY, PH_YAW, 1'b1);
         7'd37: uop = sine_uop(3'd1, D_CY, PH_YAW, 1'b1);
         7'd38: uop = sine_uop(3'd2, D_CY, PH_YAW, 1'b1);
         7'd39: uop = sine_uop(3'd3, D_CY, PH_YAW, 1'b1);
         7'd40: uop = sine_uop(3'd4, D_CY, PH_YAW, 1'b1);
         7'd41: uop = mk(M_RND,  OP_SR,  OP_SP, OP_ZERO, D_AP,  OUT_X);
         7'd42: uop = mk(M_RND,  OP_CR,  OP_SP, OP_ZERO, D_BP,  OUT_X);
         7'd43: uop = mk(M_RND,  OP_CP,  OP_CY, OP_ZERO, D_M,   OUT_X);
         7'd44: uop = mk(M_ACC0, OP_M,   OP_V0, OP_ZERO, D_NONE, OUT_X);
         7'd45: uop = mk(M_RND,  OP_AP,  OP_CY, OP_ZERO, D_TMP, OUT_X);
         7'd46: uop = mk(M_SUBR, OP_CR,  OP_SY, OP_TMP,  D_M,   OUT_X);
         7'd47: uop = mk(M_ACC,  OP_M,   OP_V1, OP_ZERO, D_NONE, OUT_X);
         7'd48: uop = mk(M_RND,  OP_BP,  OP_CY, OP_ZERO, D_TMP, OUT_X);
         7'd49: uop = mk(M_ADDR, OP_SR,  OP_SY, OP_TMP,  D_M,   OUT_X);
         7'd50: uop = mk(M_ACC,  OP_M,   OP_V2, OP_ZERO, D_NONE, OUT_X);
         7'd51: uop = mk(M_OUT,  OP_ZERO, OP_ZERO, OP_ZERO, D_NONE, OUT_X);
         7'd52: uop = mk(M_RND,  OP_CP,  OP_SY, OP_ZERO, D_M,   OUT_X);
         7'd53: uop = mk(M_ACC0, OP_M,   OP_V0, OP_ZERO, D_NONE, OUT_X);
         7'd54: uop = mk(M_RND,  OP_AP,  OP_SY, OP_ZERO, D_TMP, OUT_X);
         7'd55: uop = mk(M_ADDR, OP_CR,  OP_CY, OP_TMP,  D_M,   OUT_X);
         7'd56: uop = mk(M_ACC,  OP_M,   OP_V1, OP_ZERO, D_NONE, OUT_X);
         7'd57: uop = mk(M_RND,  OP_BP,  OP_SY, OP_ZERO, D_TMP, OUT_X);
         7'd58: uop = mk(M_SUBR, OP_SR,  OP_CY, OP_TMP,  D_M,   OUT_X);
         7'd59: uop = mk(M_ACC,  OP_M,   OP_V2, OP_ZERO, D_NONE, OUT_X);
         7'd60: uop = mk(M_OUT,  OP_ZERO, OP_ZERO, OP_ZERO, D_NONE, OUT_Y);
         7'd61: uop = mk(M_ACC0, OP_NSP, OP_V0, OP_ZERO, D_NONE, OUT_X);
         7'd62: uop = mk(M_RND,  OP_SR,  OP_CP, OP_ZERO, D_M,   OUT_X);
         7'd63: uop = mk(M_ACC,  OP_M,   OP_V1, OP_ZERO, D_NONE, OUT_X);
         7'd64: uop = mk(M_RND,  OP_CR,  OP_CP, OP_ZERO, D_M,   OUT_X);
         7'd65: uop = mk(M_ACC,  OP_M,   OP_V2, OP_ZERO, D_NONE, OUT_X);
         7'd66: uop = mk(M_OUT,  OP_ZERO, OP_ZERO, OP_ZERO, D_NONE, OUT_Z);
         default: uop = mk(M_END, OP_ZERO, OP_ZERO, OP_ZERO, D_NONE, OUT_X);
      endcase
   end

   // clamp the selected camera's geometry
   always_comb begin
      width_c = cfg_width_ff[cam_ff];
      if (width_c < cra_pkg::CAM_WIDTH_W'(cra_pkg::WIDTH_MIN))
         width_c = cra_pkg::CAM_WIDTH_W'(cra_pkg::WIDTH_MIN);
      if (width_c > cra_pkg::CAM_WIDTH_W'(cra_pkg::WIDTH_MAX))
         width_c = cra_pkg::CAM_WIDTH_W'(cra_pkg::WIDTH_MAX);
      view_c = cfg_view_ff[cam_ff];
      if (view_c < cra_pkg::VIEW_W'(cra_pkg::VIEW_MIN))
         view_c = cra_pkg::VIEW_W'(cra_pkg::VIEW_MIN);
      if (view_c > cra_pkg::VIEW_W'(cra_pkg::VIEW_MAX))
         view_c = cra_pkg::VIEW_W'(cra_pkg::VIEW_MAX);
      view_idx = VIDX_W'(view_c - cra_pkg::VIEW_W'(cra_pkg::VIEW_MIN));
   end

   // phase selection and quarter wave fold
   always_comb begin
      case (uop.ph)
         PH_VIEW:  ph_base = cra_pkg::VIEW_PHASE[view_idx];
         PH_ROLL:  ph_base = {roll_ff, {(cra_pkg::PHASE_W - ANGLE_WIDTH){1'b0}}};
         PH_PITCH: ph_base = {pitch_ff, {(cra_pkg::PHASE_W - ANGLE_WIDTH){1'b0}}};
         PH_YAW:   ph_base = pass_ff ?
                             {yaw_ff, {(cra_pkg::PHASE_W - ANGLE_WIDTH){1'b0}}} : '0;
         default:  ph_base = '0;
      endcase
      ph_sel = uop.cos ? ph_base + cra_pkg::QUARTER_TURN : ph_base;
      z_fold = ph_sel[30] ? 31'h4000_0000 - {1'b0, ph_sel[29:0]} : {1'b0, ph_sel[29:0]};
   end

   // shared multiplier with rounding
   always_comb begin
      opa     = operand(uop.a);
      opb     = operand(uop.b);
      opc     = operand(uop.c);
      prod    = opa * opb;
      rnd_src = (uop.mode == M_OUT) ? acc_ff : prod;
      rnd_val = rnd30(rnd_src);
      rnd_t   = rnd_val[OP_W-1:0];
      case (uop.mode)
         M_SUBR:   wval = opc - rnd_t;
         M_ADDR:   wval = opc + rnd_t;
         M_SINFIN: wval = neg_ff ? -rnd_t : rnd_t;
         default:  wval = rnd_t;
      endcase
   end

   // divider step and status timeouts
   always_comb begin
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      qbit     = (rem_sh >= {1'b0, den_ff});
      num_in   = {num_ff[NUM_W-2:0], qbit};
      elapsed0 = req_time_ms - last_seen_ff[0];
      elapsed1 = req_time_ms - last_seen_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         step_ff           <= '0;
         pass_ff           <= 1'b0;
         dcnt_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         cam_valid_ff      <= '0;
         last_seen_ff[0]   <= '0;
         last_seen_ff[1]   <= '0;
         cfg_width_ff[0]   <= 12'd640;
         cfg_width_ff[1]   <= 12'd640;
         cfg_view_ff[0]    <= 8'd60;
         cfg_view_ff[1]    <= 8'd60;
         cfg_timeout_ff[0] <= '0;
         cfg_timeout_ff[1] <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               cra_pkg::CSR_CAM1_WIDTH:   cfg_width_ff[0] <= csr_data[11:0];
               cra_pkg::CSR_CAM1_VIEW:    cfg_view_ff[0]  <= csr_data[7:0];
               cra_pkg::CSR_CAM2_WIDTH:   cfg_width_ff[1] <= csr_data[11:0];
               cra_pkg::CSR_CAM2_VIEW:    cfg_view_ff[1]  <= csr_data[7:0];
               cra_pkg::CSR_CAM1_TIMEOUT: cfg_timeout_ff[0] <= csr_data;
               cra_pkg::CSR_CAM2_TIMEOUT: cfg_timeout_ff[1] <= csr_data;
               default: ;
            endcase
         end

         // drop the output once the far side takes it, unless a new one loads
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_WAIT)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cam_ff        <= req_camera_sel;
                  roll_ff       <= req_roll_angle;
                  pitch_ff      <= req_pitch_angle;
                  yaw_ff        <= req_yaw_angle;
                  v1_ff         <= OP_W'(req_offset_x) <<< FRAC_BITS;
                  v2_ff         <= -(OP_W'(req_offset_y) <<< FRAC_BITS);
                  res_corr_x_ff <= '0;
                  res_corr_y_ff <= '0;
                  res_ray_x_ff  <= '0;
                  res_ray_y_ff  <= '0;
                  res_ray_z_ff  <= '0;
                  pass_ff       <= 1'b0;
                  step_ff       <= '0;
                  if (req_action) begin
                     res_updated_ff <= 1'b0;
                     res_camera_ff  <= 1'b0;
                     if (cfg_timeout_ff[0] != '0 &&
                         elapsed0 > cra_pkg::TIME_W'(cfg_timeout_ff[0]))
                        cam_valid_ff[0] <= 1'b0;
                     if (cfg_timeout_ff[1] != '0 &&
                         elapsed1 > cra_pkg::TIME_W'(cfg_timeout_ff[1]))
                        cam_valid_ff[1] <= 1'b0;
                     state_ff <= ST_WAIT;
                  end else if (!req_healthy) begin
                     res_updated_ff <= 1'b0;
                     res_camera_ff  <= req_camera_sel;
                     state_ff       <= ST_WAIT;
                  end else begin
                     res_updated_ff <= 1'b1;
                     res_camera_ff  <= req_camera_sel;
                     last_seen_ff[req_camera_sel] <= req_time_ms;
                     cam_valid_ff[req_camera_sel] <= 1'b1;
                     state_ff       <= ST_CALC;
                  end
               end
            end

            ST_CALC: begin
               step_ff <= step_ff + 7'd1;
               case (uop.dst)
                  D_Z2:  z2_ff  <= wval;
                  D_T:   t_ff   <= wval;
                  D_SH:  sh_ff  <= wval;
                  D_CH:  ch_ff  <= wval;
                  D_SR:  sr_ff  <= wval;
                  D_CR:  cr_ff  <= wval;
                  D_SP:  sp_ff  <= wval;
                  D_CP:  cp_ff  <= wval;
                  D_SY:  sy_ff  <= wval;
                  D_CY:  cy_ff  <= wval;
                  D_AP:  ap_ff  <= wval;
                  D_BP:  bp_ff  <= wval;
                  D_TMP: tmp_ff <= wval;
                  D_M:   m_ff   <= wval;
                  default: ;
               endcase
               case (uop.mode)
                  M_SINLOAD: begin
                     z_ff   <= OP_W'(z_fold);
                     neg_ff <= ph_sel[31];
                  end
                  M_ACC0: acc_ff <= prod;
                  M_ACC:  acc_ff <= acc_ff + prod;
                  M_OUT: begin
                     case (uop.out)
                        OUT_X: res_ray_x_ff <= sat_vec(rnd_val);
                        OUT_Y: begin
                           res_ray_y_ff <= sat_vec(rnd_val);
                           if (!pass_ff) res_corr_x_ff <= sat_vec(rnd_val);
                        end
                        default: begin
                           res_ray_z_ff <= sat_vec(rnd_val);
                           if (!pass_ff) res_corr_y_ff <= sat_vec(-rnd_val);
                        end
                     endcase
                  end
                  M_FNUM: begin
                     // focal = (w*cos*2^FRAC_BITS + sin) / (2*sin)
                     num_ff   <= (NUM_W'(unsigned'(prod)) << FRAC_BITS) +
                                 NUM_W'(unsigned'(sh_ff));
                     den_ff   <= DEN_W'(unsigned'(sh_ff)) << 1;
                     rem_ff   <= '0;
                     dcnt_ff  <= '0;
                     state_ff <= ST_DIV;
                  end
                  M_END: begin
                     if (pass_ff || cam_ff) begin
                        state_ff <= ST_WAIT;
                     end else begin
                        pass_ff <= 1'b1;
                        step_ff <= STEP_YAW;
                     end
                  end
                  default: ;
               endcase
            end

            ST_DIV: begin
               rem_ff  <= qbit ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
               num_ff  <= num_in;
               dcnt_ff <= dcnt_ff + DCNT_W'(1);
               if (dcnt_ff == DCNT_W'(NUM_W - 1)) begin
                  v0_ff    <= OP_W'(num_in);
                  step_ff  <= STEP_ROT;
                  state_ff <= ST_CALC;
               end
            end

            ST_WAIT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_updated_ff <= res_updated_ff;
                  rsp_camera_ff  <= res_camera_ff;
                  rsp_corr_x_ff  <= res_corr_x_ff;
                  rsp_corr_y_ff  <= res_corr_y_ff;
                  rsp_ray_x_ff   <= res_ray_x_ff;
                  rsp_ray_y_ff   <= res_ray_y_ff;
                  rsp_ray_z_ff   <= res_ray_z_ff;
                  rsp_follow_ff  <= cam_valid_ff[0];
                  rsp_avoid_ff   <= cam_valid_ff[1];
                  state_ff       <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_updated      = rsp_updated_ff;
   assign rsp_camera_out   = rsp_camera_ff;
   assign rsp_corr_x       = rsp_corr_x_ff;
   assign rsp_corr_y       = rsp_corr_y_ff;
   assign rsp_ray_x        = rsp_ray_x_ff;
   assign rsp_ray_y        = rsp_ray_y_ff;
   assign rsp_ray_z        = rsp_ray_z_ff;
   assign rsp_follow_valid = rsp_follow_ff;
   assign rsp_avoid_valid  = rsp_avoid_ff;

endmodule
`default_nettype wire

// ----- sv/cra_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cra_checker - port level checks for the camera ray attitude rotator
// Watches the result channel and binds to the top level.
// ----------------------------------------------------------------------------
module cra_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic                              rsp_updated,
   input wire logic                              rsp_camera_out,
   input wire logic signed [cra_pkg::VEC_W-1:0]  rsp_corr_x,
   input wire logic signed [cra_pkg::VEC_W-1:0]  rsp_corr_y,
   input wire logic signed [cra_pkg::VEC_W-1:0]  rsp_ray_x,
   input wire logic signed [cra_pkg::VEC_W-1:0]  rsp_ray_y,
   input wire logic signed [cra_pkg::VEC_W-1:0]  rsp_ray_z,
   input wire logic                              rsp_follow_valid,
   input wire logic                              rsp_avoid_valid
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // nothing offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // a result without new vectors carries zero vectors
   a_zero_vectors: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_updated |-> rsp_corr_x == '0 && rsp_corr_y == '0 &&
         rsp_ray_x == '0 && rsp_ray_y == '0 && rsp_ray_z == '0)
      else $error("non-updated result with vectors");

   // an update marks its own camera valid
   a_update_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_updated |->
         (rsp_camera_out ? rsp_avoid_valid : rsp_follow_valid))
      else $error("updated camera not flagged valid");

endmodule

bind camera_ray_attitude_rotate cra_checker u_cra_checker (.*);
`default_nettype wire
